// ===== rtl/rta_pkg.sv =====
// ----------------------------------------------------------------------------
// Region table allocator package
// Sizes, command, status and register codes that the allocator files share.
// ----------------------------------------------------------------------------
package rta_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BYTES  = 4096;

  localparam int IDX_W = $clog2(MAX_REGIONS);       // table address
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);   // fill count, holds MAX_REGIONS

  localparam int ENTRY_W = 64;                      // {length, start}
  localparam int IN_W    = 72;
  localparam int OUT_W   = 72;

  localparam logic [32:0] PAGE_USED = 33'(PAGE_BYTES);
  localparam logic [31:0] PAGE_LEN  = 32'(PAGE_BYTES);

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // configuration register indexes
  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ALLOC = 8'b0000_0010,
    S_AWR   = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_CMP   = 8'b0001_0000,
    S_LWR   = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/rta_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/region_table_allocator_top.sv =====
// Allocate: room test, then entry 0 written on an empty table, else last entry read and
//   the new one written after it. Release and check read and compare filled entries one
//   at a time (all on a miss, at most 64); a release then moves the last entry into the
//   hole. An unknown command goes straight to the result. Output stalls add on top.
// Throughput: one command at a time, next transfer in the cycle after the result loads.
// Reset (rst_n low, sync): one page entry at pool_base, one page used, pool regs zero.
// ----------------------------------------------------------------------------
// Region table allocator, top level
// Bump allocator over a table of regions with room test, release with hole
// fill from the last entry, and address containment check.
// ----------------------------------------------------------------------------
module region_table_allocator_top
  import rta_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic             cfg_addr,        // 0 pool_base, 1 pool_size
  input  logic [31:0]      cfg_wdata,
  // command stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,        // cmd[1:0], req_size[33:2], req_address[65:34]
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata        // result_address[31:0], released_size[63:32],
                                            // inside_res[64], status[66:65]
);

  state_t state_r, state_nxt;

  logic [31:0]      pool_base_r, pool_size_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [32:0]      used_r, used_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             e0_ok_r, e0_ok_nxt;      // entry 0 has been written since rebuild

  // latched command
  logic [1:0]  cmd_r, cmd_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] addr_r, addr_nxt;

  // result being built
  logic [31:0] res_addr_r, res_addr_nxt;
  logic [31:0] res_len_r, res_len_nxt;
  logic        res_in_r, res_in_nxt;
  logic [1:0]  res_st_r, res_st_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // table RAM
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr, rd_addr_r;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [31:0]        rd_start, rd_len;

  // shared adder
  logic [33:0] add_a, add_b;
  logic        add_ci;
  logic [34:0] add_sum;

  logic in_xfer;
  logic last_hit;

  rta_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_REGIONS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Entry 0 reads as the bookkeeping page until it is overwritten.
  assign rd_start = (rd_addr_r == '0 && !e0_ok_r) ? pool_base_r : ram_rdata[31:0];
  assign rd_len   = (rd_addr_r == '0 && !e0_ok_r) ? PAGE_LEN    : ram_rdata[63:32];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {34'd0, add_ci};

  // Operand select for the one adder: room test, end address, lower bound
  // test of a check, used total decrement of a release.
  always_comb begin
    add_a  = {1'b0, used_r};
    add_b  = {2'b00, size_r};
    add_ci = 1'b0;
    case (state_r)
      S_AWR: begin
        add_a = {2'b00, rd_start};
        add_b = {2'b00, rd_len};
      end
      S_CMP: begin
        if (cmd_r == CMD_CHECK) begin
          add_a  = {2'b00, addr_r};
          add_b  = ~{2'b00, rd_start};
          add_ci = 1'b1;
        end else begin
          add_a  = {1'b0, used_r};
          add_b  = ~{2'b00, rd_len};
          add_ci = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // release: exact start match; check: start <= addr < start + len, no wrap
  assign last_hit = (cmd_r == CMD_CHECK)
                  ? (add_sum[34] && (add_sum[31:0] < rd_len))
                  : (rd_start == addr_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    e0_ok_nxt     = e0_ok_r;
    cmd_nxt       = cmd_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    res_addr_nxt  = res_addr_r;
    res_len_nxt   = res_len_r;
    res_in_nxt    = res_in_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata     = {size_r, rd_start};
    ram_raddr     = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt      = in_tdata[1:0];
          size_nxt     = in_tdata[33:2];
          addr_nxt     = in_tdata[65:34];
          idx_nxt      = '0;
          res_addr_nxt = '0;
          res_len_nxt  = '0;
          res_in_nxt   = 1'b0;
          res_st_nxt   = ST_DONE;
          case (in_tdata[1:0])
            CMD_ALLOC:   state_nxt = S_ALLOC;
            CMD_RELEASE: state_nxt = S_RD;
            CMD_CHECK:   state_nxt = S_RD;
            default:     state_nxt = S_DONE;
          endcase
        end
      end

      S_ALLOC: begin
        ram_raddr = IDX_W'(count_r - 1'b1);
        if (add_sum > {3'b000, pool_size_r} || count_r >= CNT_W'(MAX_REGIONS)) begin
          res_st_nxt = ST_NO_ROOM;
          state_nxt  = S_DONE;
        end else begin
          used_nxt = add_sum[32:0];
          if (count_r == '0) begin
            ram_we       = 1'b1;
            ram_waddr    = '0;
            ram_wdata    = {size_r, pool_base_r};
            e0_ok_nxt    = 1'b1;
            res_addr_nxt = pool_base_r;
            count_nxt    = count_r + 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_AWR;
          end
        end
      end

      S_AWR: begin
        // last entry is on the read port; new region starts at its end, mod 2^32
        ram_we       = 1'b1;
        ram_wdata    = {size_r, add_sum[31:0]};
        res_addr_nxt = add_sum[31:0];
        count_nxt    = count_r + 1'b1;
        state_nxt    = S_DONE;
      end

      S_RD: begin
        if (idx_r >= count_r) begin
          if (cmd_r == CMD_RELEASE) begin
            res_st_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        if (last_hit) begin
          if (cmd_r == CMD_CHECK) begin
            res_in_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            res_addr_nxt = addr_r;
            res_len_nxt  = rd_len;
            used_nxt     = add_sum[34] ? add_sum[32:0] : '0;
            ram_raddr    = IDX_W'(count_r - 1'b1);
            state_nxt    = S_LWR;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end

      S_LWR: begin
        // move the last entry into the hole
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = {rd_len, rd_start};
        if (idx_r == '0) begin
          e0_ok_nxt = 1'b1;
        end
        count_nxt = count_r - 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, res_st_r, res_in_r, res_len_r, res_addr_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // pool_base write rebuilds the table (the user writes it only while idle; not enforced here)
    if (cfg_we && cfg_addr == REG_POOL_BASE) begin
      count_nxt = CNT_W'(1);
      used_nxt  = PAGE_USED;
      e0_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pool_base_r <= '0;
      pool_size_r <= '0;
      count_r     <= CNT_W'(1);
      used_r      <= PAGE_USED;
      idx_r       <= '0;
      e0_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      e0_ok_r     <= e0_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_addr == REG_POOL_BASE) begin
          pool_base_r <= cfg_wdata;
        end else begin
          pool_size_r <= cfg_wdata;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    res_addr_r <= res_addr_nxt;
    res_len_r  <= res_len_nxt;
    res_in_r   <= res_in_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
    rd_addr_r  <= ram_raddr;
  end

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table depth");

  // a base write leaves a one-entry table with one page in use
  a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_addr == REG_POOL_BASE |=> count_r == CNT_W'(1) && used_r == PAGE_USED)
    else $error("table not rebuilt after pool base write");

  // the scan compares only filled entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> idx_r < count_r)
    else $error("scan compare past last entry");

endmodule

// ===== tb/region_table_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region table monitor
// Watches the register port and both streams, keeps its own copy of the
// region table, predicts one result per accepted command and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module region_table_monitor
  import rta_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               mismatches,
  output int               outstanding
);

  // same bit order as out_tdata[66:0]
  typedef struct packed {
    logic [1:0]  status;
    logic        in_region;
    logic [31:0] freed_len;
    logic [31:0] addr;
  } answer_t;

  logic [31:0] base_reg;
  logic [31:0] limit_reg;
  logic [31:0] tbl_start [MAX_REGIONS];
  logic [31:0] tbl_len   [MAX_REGIONS];
  int unsigned tbl_count;
  logic [32:0] used_bytes;
  answer_t     answer_q [$];

  task automatic rebuild_table();
    for (int i = 0; i < MAX_REGIONS; i++) begin
      tbl_start[i] = '0;
      tbl_len[i]   = '0;
    end
    tbl_start[0] = base_reg;
    tbl_len[0]   = 32'(PAGE_BYTES);
    tbl_count    = 1;
    used_bytes   = 33'(PAGE_BYTES);
  endtask

  // Applies one command to the local table and returns the result it gives.
  function automatic answer_t serve_command(logic [1:0] cmd, logic [31:0] amount,
                                            logic [31:0] addr);
    answer_t     ans;
    int unsigned hit;
    logic [33:0] need;
    logic [31:0] tail;
    logic [31:0] len;
    ans = '0;
    case (cmd)
      CMD_ALLOC: begin
        // room test is done wide, no wrap
        need = {1'b0, used_bytes} + {2'b00, amount};
        if (need > {2'b00, limit_reg} || tbl_count >= MAX_REGIONS) begin
          ans.status = ST_NO_ROOM;
        end else begin
          if (tbl_count == 0) tail = base_reg;
          else tail = tbl_start[tbl_count-1] + tbl_len[tbl_count-1];
          tbl_start[tbl_count] = tail;
          tbl_len[tbl_count]   = amount;
          tbl_count++;
          used_bytes = used_bytes + {1'b0, amount};
          ans.addr   = tail;
        end
      end
      CMD_RELEASE: begin
        hit = tbl_count;
        for (int i = 0; i < MAX_REGIONS; i++) begin
          if (i < tbl_count && hit == tbl_count && tbl_start[i] == addr) hit = i;
        end
        if (hit == tbl_count) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          len           = tbl_len[hit];
          ans.addr      = addr;
          ans.freed_len = len;
          if (used_bytes >= {1'b0, len}) used_bytes = used_bytes - {1'b0, len};
          else used_bytes = '0;
          // last entry fills the hole
          tbl_start[hit] = tbl_start[tbl_count-1];
          tbl_len[hit]   = tbl_len[tbl_count-1];
          tbl_count--;
        end
      end
      CMD_CHECK: begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
          if (i < tbl_count && addr >= tbl_start[i] &&
              32'(addr - tbl_start[i]) < tbl_len[i]) ans.in_region = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic flag_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      base_reg  = '0;
      limit_reg = '0;
      rebuild_table();
      answer_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_POOL_BASE) begin
          base_reg = cfg_wdata;
          rebuild_table();
        end else begin
          limit_reg = cfg_wdata;
        end
      end
      // result side first: a result in the same cycle belongs to an older command
      if (out_tvalid && out_tready) begin
        got = out_tdata[66:0];
        if (answer_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = answer_q.pop_front();
          flag_field("address", want.addr, got.addr);
          flag_field("released size", want.freed_len, got.freed_len);
          flag_field("inside", 32'(want.in_region), 32'(got.in_region));
          flag_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (in_tvalid && in_tready)
        answer_q.push_back(serve_command(in_tdata[1:0], in_tdata[33:2], in_tdata[65:34]));
    end
    outstanding = answer_q.size();
  end

endmodule

// ===== tb/region_table_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region table allocator testbench
// Directed commands on the table edges (wrap of the tail address, zero-size
// regions, empty table, full room test), then random phases under several
// pool settings, most with random gaps and back-pressure. The monitor predicts and
// checks every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module region_table_allocator_top_tb;
  import rta_pkg::*;

  // command code the block must answer with all-zero fields
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_addr;
  logic [31:0]      cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // cmd[1:0], req_size[33:2], req_address[65:34]
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // result_address[31:0], released_size[63:32],
                                // inside_res[64], status[66:65]

  int          mismatches;
  int          outstanding;
  bit          idle_on;         // random gaps between command transfers
  bit          stall_on;        // random back-pressure on the result side
  logic [31:0] cur_base;        // pool base last written, steers addresses

  region_table_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  region_table_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result-side ready: random bursts of stall mixed with open
  // stretches; once stall_on drops it stays high for good.
  initial begin : ready_gen
    int span;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 12);
      end else begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 30);
      end
      repeat (span) @(negedge clk);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("region_table_allocator_top regression: fail");
    $finish;
  end

  // One command transfer. Entered and left at a falling edge; tvalid is left
  // high so back-to-back commands go out without a gap. A caller that stops
  // sending drops tvalid itself.
  task automatic issue(input logic [1:0] cmd, input logic [31:0] amount,
                       input logic [31:0] addr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, addr, amount, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Register write, only called with the block idle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    if (idx == REG_POOL_BASE) cur_base = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result come back, plus a short
  // pause so the block is back in idle before the registers move.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mostly well-formed traffic: page-sized allocates, releases aimed at the
  // page grid from the pool base (where region starts land), checks near the
  // pool; a slice of full-range noise so every bit of every field moves.
  task automatic issue_random();
    int          pick;
    int          k;
    logic [31:0] amount;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, 19);
    if (pick < 45) begin
      if (k == 0) amount = $urandom;
      else if (k == 1) amount = 32'hFFFF_FFFF;
      else if (k < 6) amount = $urandom_range(0, 5000);
      else amount = 4096 * $urandom_range(0, 4);
      issue(CMD_ALLOC, amount, $urandom);
    end else if (pick < 75) begin
      if (k < 2) addr = $urandom;
      else if (k < 4) addr = cur_base + $urandom_range(0, 8191);
      else addr = cur_base + 4096 * $urandom_range(0, 64);
      issue(CMD_RELEASE, $urandom, addr);
    end else if (pick < 95) begin
      if (k < 2) addr = $urandom;
      else addr = cur_base + $urandom_range(0, 4096 * 80);
      issue(CMD_CHECK, $urandom, addr);
    end else begin
      issue(CMD_UNUSED, $urandom, $urandom);
    end
  endtask

  task automatic run_phase(input bit new_base, input logic [31:0] base,
                           input logic [31:0] limit, input int count, input bit quiet);
    settle();
    if (new_base) write_reg(REG_POOL_BASE, base);
    write_reg(REG_POOL_SIZE, limit);
    idle_on  = !quiet;
    stall_on = !quiet;
    repeat (count) issue_random();
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_POOL_BASE;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cur_base  = '0;
    idle_on   = 1'b1;
    stall_on  = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Base near the top of the address space so the tail
    // address wraps; size at its maximum.
    write_reg(REG_POOL_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_POOL_BASE, 32'hFFFF_E000);       // table rebuilt at the new base
    issue(CMD_CHECK,   32'h0000_0000, 32'hFFFF_E000);  // first byte of bookkeeping page
    issue(CMD_CHECK,   32'hFFFF_FFFF, 32'hFFFF_EFFF);  // last byte
    issue(CMD_CHECK,   32'h0000_0000, 32'hFFFF_F000);  // one past the end
    issue(CMD_ALLOC,   32'h0000_1000, 32'h0000_0000);
    issue(CMD_ALLOC,   32'h0000_0000, 32'hFFFF_FFFF);  // zero size, start wraps to 0
    issue(CMD_CHECK,   32'h0000_0000, 32'h0000_0000);  // empty region holds nothing
    issue(CMD_CHECK,   32'h0000_0000, 32'hFFFF_FFFF);
    issue(CMD_ALLOC,   32'hFFFF_FFFF, 32'h0000_0000);  // room test must not wrap
    issue(CMD_RELEASE, 32'h0000_0000, 32'h1234_5678);  // no match
    issue(CMD_RELEASE, 32'h0000_0000, 32'h0000_0000);  // last entry
    issue(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_E000);  // hole filled by last entry
    issue(CMD_CHECK,   32'h0000_0000, 32'hFFFF_E000);
    issue(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_F000);  // table now empty
    issue(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_F000);  // nothing left to match
    issue(CMD_CHECK,   32'h0000_0000, 32'hFFFF_F000);
    issue(CMD_ALLOC,   32'h0000_2000, 32'h0000_0000);  // empty table: starts at base
    issue(CMD_UNUSED,  $urandom,      $urandom);
    settle();
    write_reg(REG_POOL_SIZE, 32'h0000_3000);       // limit only, table kept
    issue(CMD_ALLOC,   32'h0000_1000, 32'h0000_0000);  // fills the pool exactly
    issue(CMD_ALLOC,   32'h0000_0001, 32'h0000_0000);  // one byte too many
    issue(CMD_CHECK,   32'h0000_0000, 32'hFFFF_F800);
    issue(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_E000);
    issue(CMD_ALLOC,   32'h0000_1000, 32'h0000_0000);
    issue(CMD_CHECK,   32'h0000_0000, 32'h0000_1000);

    // Random phases: mid pool, everything at its maximum (table fills up),
    // everything zero (every allocate refused), limit only, then a last
    // stretch without gaps or stalls.
    run_phase(1'b1, 32'h1000_0000, 32'h0010_0000, 450, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 500, 1'b0);
    run_phase(1'b1, 32'h0000_0000, 32'h0000_0000, 100, 1'b0);
    run_phase(1'b0, 32'h0000_0000, $urandom_range(32'h8000, 32'h4_0000), 350, 1'b0);
    run_phase(1'b1, $urandom, 32'h0004_0000, 350, 1'b1);

    // Drain, then give a late or extra result time to show up.
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("region_table_allocator_top regression: pass");
    end else begin
      $display("region_table_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rta_pkg.sv
rtl/rta_ram.sv
rtl/region_table_allocator_top.sv
tb/region_table_monitor.sv
tb/region_table_allocator_top_tb.sv
